### hdl/fdcs_pkg.sv
package fdcs_pkg;

  localparam int NUM_SERVERS = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 6;
  localparam int ID_BITS     = 16;

  localparam int SRV_W = 2;
  localparam int QA_W  = $clog2(QUEUE_DEPTH);
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

  // event buffer: a finish and a start per server at most
  localparam int EVT_DEPTH = 2 * NUM_SERVERS;
  localparam int EA_W      = $clog2(EVT_DEPTH);
  localparam int EC_W      = $clog2(EVT_DEPTH + 1);

  localparam int CFG_W = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

  typedef enum logic [1:0] {
    EV_SUMMARY = 2'd0,
    EV_FINISH  = 2'd1,
    EV_START   = 2'd2
  } evt_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEC,
    ST_START,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic rd;
  } queue_ctrl_t;

endpackage

### hdl/fdcs_queue.sv
module fdcs_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  fdcs_pkg::queue_ctrl_t         ctrl,
  input  logic [fdcs_pkg::ID_BITS-1:0]  push_id,
  input  logic [fdcs_pkg::TIME_BITS-1:0] push_time,
  output logic [fdcs_pkg::ID_BITS-1:0]  head_id,
  output logic [fdcs_pkg::TIME_BITS-1:0] head_time,
  output logic [fdcs_pkg::QC_W-1:0]     fill,
  output logic                          full
);
  import fdcs_pkg::*;

  logic [ID_BITS-1:0]   mem_id   [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] mem_time [QUEUE_DEPTH];
  logic [QA_W-1:0]      head;
  logic [QA_W-1:0]      tail;

  function automatic logic [QA_W-1:0] wrap_inc(input logic [QA_W-1:0] i);
    if (i == QA_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return i + QA_W'(1);
  endfunction

  assign full = (fill == QC_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem_id[tail]   <= push_id;
      mem_time[tail] <= push_time;
    end
    if (ctrl.rd) begin
      head_id   <= mem_id[head];
      head_time <= mem_time[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (ctrl.push) begin
        tail <= wrap_inc(tail);
      end
      if (ctrl.pop) begin
        head <= wrap_inc(head);
      end
      fill <= fill + QC_W'(ctrl.push) - QC_W'(ctrl.pop);
    end
  end

endmodule

### hdl/fifo_dispatch_to_countdown_servers_top.sv
// Steps: the request is taken in the idle state, then each server in use is visited
// (count down, then start), then one output record per event plus the summary.
// The per-server visit loop sets the tick rate; a new request is taken only after
// the summary record of the last tick is accepted. Ready only when idle.
// Reset (rst, synchronous, active high): queue empty, all servers idle, next id 1,
// servers_in_use 4. Queue storage is not cleared.
module fifo_dispatch_to_countdown_servers_top (
  input  logic        clk,
  input  logic        rst,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  // input: [0] arrival, [6:1] service_time
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // output: [1:0] server_index, [17:2] customer_id, [23:18] job_time,
  //         [28:24] queue_count, [32:29] busy_mask, [33] arrival_rejected
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  // tuser: [1:0] event_kind
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);
  import fdcs_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0]     servers_in_use;
  logic [SRV_W-1:0]     srv_last;
  logic [SRV_W-1:0]     srv;
  logic [TIME_BITS-1:0] remaining [NUM_SERVERS];
  logic [ID_BITS-1:0]   job       [NUM_SERVERS];
  logic [ID_BITS-1:0]   next_id;
  logic                 rejected;

  evt_kind_t            ev_kind [EVT_DEPTH];
  logic [SRV_W-1:0]     ev_srv  [EVT_DEPTH];
  logic [ID_BITS-1:0]   ev_id   [EVT_DEPTH];
  logic [TIME_BITS-1:0] ev_time [EVT_DEPTH];
  logic [EC_W-1:0]      ev_cnt;
  logic [EC_W-1:0]      rd_ptr;

  queue_ctrl_t          qctrl;
  logic [ID_BITS-1:0]   head_id;
  logic [TIME_BITS-1:0] head_time;
  logic [QC_W-1:0]      fill;
  logic                 full;

  logic [TIME_BITS-1:0] in_time;
  logic [NUM_SERVERS-1:0] busy_mask;
  logic                 in_acc;
  logic                 out_acc;
  logic                 emit_summary;
  logic                 rem_nz;
  logic                 do_start;

  fdcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (qctrl),
    .push_id   (next_id),
    .push_time (in_time),
    .head_id   (head_id),
    .head_time (head_time),
    .fill      (fill),
    .full      (full)
  );

  // zero service time counts as one tick
  assign in_time = (s_tdata[6:1] == '0) ? TIME_BITS'(1) : s_tdata[6:1];

  always_comb begin
    if (servers_in_use == '0) begin
      srv_last = '0;
    end else if (servers_in_use > CFG_W'(NUM_SERVERS)) begin
      srv_last = SRV_W'(NUM_SERVERS - 1);
    end else begin
      srv_last = SRV_W'(servers_in_use - CFG_W'(1));
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SERVERS; i++) begin
      busy_mask[i] = (remaining[i] != '0);
    end
  end

  assign rem_nz       = (remaining[srv] != '0);
  assign do_start     = !rem_nz && (fill != '0);
  assign in_acc       = s_tvalid && s_tready;
  assign out_acc      = m_tvalid && m_tready;
  assign emit_summary = (rd_ptr == ev_cnt);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) begin
        state_next = ST_DEC;
      end
      ST_DEC:   state_next = ST_START;
      ST_START: if (srv == srv_last) begin
        state_next = ST_EMIT;
      end else begin
        state_next = ST_DEC;
      end
      ST_EMIT:  if (m_tready && emit_summary) begin
        state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready  = 1'b0;
    m_tvalid  = 1'b0;
    qctrl     = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        qctrl.push = s_tvalid && s_tdata[0] && !full;
      end
      ST_DEC:   qctrl.rd  = 1'b1;
      ST_START: qctrl.pop = do_start;
      ST_EMIT:  m_tvalid  = 1'b1;
      default: ;
    endcase
  end

  // config lands only between ticks, never beside a request
  assign cfg_ready = (state == ST_IDLE) && !s_tvalid;

  always_comb begin
    m_tdata       = '0;
    m_tdata[28:24] = fill;
    m_tdata[32:29] = busy_mask;
    if (emit_summary) begin
      m_tuser     = EV_SUMMARY;
      m_tlast     = 1'b1;
      m_tdata[33] = rejected;
    end else begin
      m_tuser        = ev_kind[rd_ptr[EA_W-1:0]];
      m_tlast        = 1'b0;
      m_tdata[1:0]   = ev_srv[rd_ptr[EA_W-1:0]];
      m_tdata[17:2]  = ev_id[rd_ptr[EA_W-1:0]];
      m_tdata[23:18] = ev_time[rd_ptr[EA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DEC && remaining[srv] == TIME_BITS'(1)) begin
      ev_kind[ev_cnt[EA_W-1:0]] <= EV_FINISH;
      ev_srv[ev_cnt[EA_W-1:0]]  <= srv;
      ev_id[ev_cnt[EA_W-1:0]]   <= job[srv];
      ev_time[ev_cnt[EA_W-1:0]] <= '0;
    end else if (state == ST_START && do_start) begin
      ev_kind[ev_cnt[EA_W-1:0]] <= EV_START;
      ev_srv[ev_cnt[EA_W-1:0]]  <= srv;
      ev_id[ev_cnt[EA_W-1:0]]   <= head_id;
      ev_time[ev_cnt[EA_W-1:0]] <= head_time;
    end
    if (in_acc) begin
      rejected <= s_tdata[0] && full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      servers_in_use <= CFG_RESET;
      srv            <= '0;
      next_id        <= ID_BITS'(1);
      ev_cnt         <= '0;
      rd_ptr         <= '0;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        remaining[i] <= '0;
        job[i]       <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        servers_in_use <= cfg_data;
      end
      unique case (state)
        ST_IDLE: if (in_acc) begin
          srv    <= '0;
          ev_cnt <= '0;
          rd_ptr <= '0;
          if (qctrl.push) begin
            next_id <= next_id + ID_BITS'(1);
          end
        end
        ST_DEC: if (rem_nz) begin
          remaining[srv] <= remaining[srv] - TIME_BITS'(1);
          if (remaining[srv] == TIME_BITS'(1)) begin
            job[srv] <= '0;
            ev_cnt   <= ev_cnt + EC_W'(1);
          end
        end
        ST_START: begin
          if (do_start) begin
            remaining[srv] <= head_time;
            job[srv]       <= head_id;
            ev_cnt         <= ev_cnt + EC_W'(1);
          end
          srv <= srv + SRV_W'(1);
        end
        ST_EMIT: if (out_acc && !emit_summary) begin
          rd_ptr <= rd_ptr + EC_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule
